// ----- rtl/robust_rotzoom_hessian_accumulator_macros.svh -----
// Assertion macros used by the top level for its concurrent checks.
`ifndef ROBUST_ROTZOOM_HESSIAN_ACCUMULATOR_MACROS_SVH
`define ROBUST_ROTZOOM_HESSIAN_ACCUMULATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRHA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define RRHA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

`endif

// ----- rtl/rrha_pkg.sv -----
// Shared constants, types and helper functions of the Hessian accumulator.
package rrha_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COORD_BITS  = 12;
    localparam int ACC_BITS    = 64;
    localparam int DIFF_BITS   = SAMPLE_BITS + 1;
    localparam int POS_BITS    = COORD_BITS + 2;
    localparam int PROD_BITS   = POS_BITS + DIFF_BITS;
    localparam int ETERM_BITS  = PROD_BITS + 1;
    localparam int CX_BITS     = 13;
    localparam int THR_BITS    = 16;
    localparam int INV_BITS    = 24;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;
    localparam int SQ_BITS     = 2 * SAMPLE_BITS;
    localparam int W_BITS      = 25;
    localparam int W_FRAC      = 24;
    localparam int DEN_BITS    = 42;
    localparam int NUM_BITS    = 57;
    localparam int WCNT_BITS   = 5;
    localparam int NUM_H       = 10;
    localparam int NUM_B       = 4;
    localparam int NUM_SUMS    = NUM_H + NUM_B;
    localparam int IDX_BITS    = 4;
    localparam int MUL_BITS    = 32;
    localparam int FIFO_DEPTH  = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CENTER_X   = 3'd0,
        CFG_CENTER_Y   = 3'd1,
        CFG_THRESHOLD  = 3'd2,
        CFG_WEIGHT_EN  = 3'd3,
        CFG_INV_SIGMA  = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SQUARE,
        F_PROD,
        F_DINIT,
        F_DIV,
        F_SCALE,
        F_MULT,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MAC,
        B_EMIT
    } back_state_t;

    // One classified pixel as handed from the front to the back.
    typedef struct packed {
        logic signed [ETERM_BITS-1:0] e0;
        logic signed [ETERM_BITS-1:0] e1;
        logic signed [DIFF_BITS-1:0]  dx;
        logic signed [DIFF_BITS-1:0]  dy;
        logic signed [DIFF_BITS-1:0]  it;
        logic                         last;
    } eterm_item_t;

    localparam logic [IDX_BITS-1:0] LAST_INDEX = IDX_BITS'(NUM_SUMS - 1);
    localparam logic [IDX_BITS-1:0] MAC_END    = IDX_BITS'(NUM_SUMS);
    localparam logic [IDX_BITS-1:0] FIRST_B    = IDX_BITS'(NUM_H);

    function automatic logic [DIFF_BITS-1:0] abs_diff(input logic signed [DIFF_BITS-1:0] v);
        logic [DIFF_BITS-1:0] r;
        r = v[DIFF_BITS-1] ? DIFF_BITS'(-v) : DIFF_BITS'(v);
        return r;
    endfunction

    // Row and column of each Hessian entry in the lower-triangle order.
    function automatic logic [1:0] hess_row(input logic [IDX_BITS-1:0] k);
        logic [1:0] r;
        unique case (k)
            4'd0:    r = 2'd0;
            4'd1:    r = 2'd1;
            4'd2:    r = 2'd1;
            4'd3:    r = 2'd2;
            4'd4:    r = 2'd2;
            4'd5:    r = 2'd2;
            default: r = 2'd3;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] hess_col(input logic [IDX_BITS-1:0] k);
        logic [1:0] r;
        unique case (k)
            4'd0:    r = 2'd0;
            4'd1:    r = 2'd0;
            4'd2:    r = 2'd1;
            4'd3:    r = 2'd0;
            4'd4:    r = 2'd1;
            4'd5:    r = 2'd2;
            4'd6:    r = 2'd0;
            4'd7:    r = 2'd1;
            4'd8:    r = 2'd2;
            default: r = 2'd3;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/rrha_fifo.sv -----
// Short queue that decouples the pixel front end from the accumulator back end.
module rrha_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  rrha_pkg::eterm_item_t  push_item,
    output logic                   full,
    input  logic                   pop,
    output rrha_pkg::eterm_item_t  pop_item,
    output logic                   empty
);
    localparam int PTR_BITS = $clog2(rrha_pkg::FIFO_DEPTH);
    localparam int CNT_BITS = $clog2(rrha_pkg::FIFO_DEPTH + 1);

    rrha_pkg::eterm_item_t store_reg [rrha_pkg::FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;

    assign full     = (count_reg == CNT_BITS'(rrha_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = store_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(rrha_pkg::FIFO_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(rrha_pkg::FIFO_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/rrha_front.sv -----
// Front end: accepts pixels, forms gradients, applies threshold and optional robust weight, builds e terms.
module rrha_front (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  logic signed [rrha_pkg::SAMPLE_BITS-1:0]    s_warped_right,
    input  logic signed [rrha_pkg::SAMPLE_BITS-1:0]    s_warped_left,
    input  logic signed [rrha_pkg::SAMPLE_BITS-1:0]    s_warped_up,
    input  logic signed [rrha_pkg::SAMPLE_BITS-1:0]    s_warped_down,
    input  logic signed [rrha_pkg::SAMPLE_BITS-1:0]    s_warped_center,
    input  logic signed [rrha_pkg::SAMPLE_BITS-1:0]    s_reference_center,
    input  logic [rrha_pkg::COORD_BITS-1:0]            s_pixel_x,
    input  logic [rrha_pkg::COORD_BITS-1:0]            s_pixel_y,
    input  logic                                       s_sample_invalid,
    input  logic                                       s_last_pixel,
    input  logic [rrha_pkg::CX_BITS-1:0]               center_x_twice,
    input  logic [rrha_pkg::CX_BITS-1:0]               center_y_twice,
    input  logic [rrha_pkg::THR_BITS-1:0]              grad_threshold,
    input  logic                                       weight_enable,
    input  logic [rrha_pkg::INV_BITS-1:0]              inv_sigma_sq,
    output logic                                       push,
    output rrha_pkg::eterm_item_t                      push_item,
    input  logic                                       full
);
    localparam int DB = rrha_pkg::DIFF_BITS;
    localparam int PB = rrha_pkg::POS_BITS;
    localparam int WB = rrha_pkg::W_BITS;
    localparam int SCALED_BITS = DB + WB;
    localparam int PMUL_BITS = rrha_pkg::SQ_BITS + rrha_pkg::INV_BITS + 1;
    localparam int P_BITS = PMUL_BITS - 16;

    rrha_pkg::front_state_t state_reg, state_next;

    logic signed [DB-1:0] dx_reg, dy_reg, it_reg;
    logic signed [PB-1:0] x2_reg, y2_reg;
    logic                 last_reg;
    logic [rrha_pkg::SQ_BITS-1:0]  sq_reg;
    logic [rrha_pkg::DEN_BITS-1:0] den_reg;
    logic [rrha_pkg::DEN_BITS-1:0] rem_reg;
    logic [WB-1:0]                 num_low_reg;
    logic [WB-1:0]                 quo_reg;
    logic [rrha_pkg::WCNT_BITS-1:0] cnt_reg;
    logic signed [rrha_pkg::PROD_BITS-1:0] p0_reg, p1_reg, p2_reg, p3_reg;

    logic accept;
    logic signed [DB-1:0] in_dx, in_dy, in_it;
    logic [DB-1:0] thr2;
    logic drop;
    logic [PMUL_BITS-1:0] pmul;
    logic [P_BITS-1:0] p_val;
    logic [rrha_pkg::NUM_BITS-1:0] num_val;
    logic [rrha_pkg::DEN_BITS:0] trial;
    logic trial_ge;

    function automatic logic signed [DB-1:0] scale_w(input logic signed [DB-1:0] v,
                                                     input logic [WB-1:0] w);
        logic [DB-1:0] m;
        logic [SCALED_BITS-1:0] pr;
        logic [DB-1:0] r;
        m  = rrha_pkg::abs_diff(v);
        pr = SCALED_BITS'(m * w) + SCALED_BITS'(1 << (rrha_pkg::W_FRAC - 1));
        r  = pr[rrha_pkg::W_FRAC +: DB];
        return v[DB-1] ? $signed(-r) : $signed(r);
    endfunction

    assign accept = s_valid && s_ready;
    assign in_dx  = DB'(s_warped_right) - DB'(s_warped_left);
    assign in_dy  = DB'(s_warped_down) - DB'(s_warped_up);
    assign in_it  = DB'(s_warped_center) - DB'(s_reference_center);
    assign thr2   = {grad_threshold, 1'b0};
    // The invalid flag or the current pixel's gradients decide the drop; for a valid pixel both must be small.
    assign drop   = s_sample_invalid
                    || ((rrha_pkg::abs_diff(in_dx) < thr2) && (rrha_pkg::abs_diff(in_dy) < thr2));

    assign pmul    = PMUL_BITS'(sq_reg * inv_sigma_sq) + PMUL_BITS'(16'h8000);
    assign p_val   = pmul[PMUL_BITS-1:16];
    assign num_val = (rrha_pkg::NUM_BITS'(1) << 56)
                     + rrha_pkg::NUM_BITS'(den_reg >> 1);
    assign trial    = {rem_reg, num_low_reg[WB-1]};
    assign trial_ge = (trial >= {1'b0, den_reg});

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rrha_pkg::F_IDLE: begin
                if (accept) begin
                    state_next = weight_enable ? rrha_pkg::F_SQUARE : rrha_pkg::F_MULT;
                end
            end
            rrha_pkg::F_SQUARE: state_next = rrha_pkg::F_PROD;
            rrha_pkg::F_PROD:   state_next = rrha_pkg::F_DINIT;
            rrha_pkg::F_DINIT:  state_next = rrha_pkg::F_DIV;
            rrha_pkg::F_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = rrha_pkg::F_SCALE;
                end
            end
            rrha_pkg::F_SCALE:  state_next = rrha_pkg::F_MULT;
            rrha_pkg::F_MULT:   state_next = rrha_pkg::F_PUSH;
            rrha_pkg::F_PUSH: begin
                if (!full) begin
                    state_next = rrha_pkg::F_IDLE;
                end
            end
            default: state_next = rrha_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == rrha_pkg::F_IDLE);
        push    = (state_reg == rrha_pkg::F_PUSH) && !full;
        push_item.e0   = rrha_pkg::ETERM_BITS'(p0_reg) + rrha_pkg::ETERM_BITS'(p1_reg);
        push_item.e1   = rrha_pkg::ETERM_BITS'(p2_reg) - rrha_pkg::ETERM_BITS'(p3_reg);
        push_item.dx   = dx_reg;
        push_item.dy   = dy_reg;
        push_item.it   = it_reg;
        push_item.last = last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rrha_pkg::F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            rrha_pkg::F_IDLE: begin
                if (accept) begin
                    dx_reg   <= drop ? '0 : in_dx;
                    dy_reg   <= drop ? '0 : in_dy;
                    it_reg   <= drop ? '0 : in_it;
                    x2_reg   <= $signed({1'b0, s_pixel_x, 1'b0}) - $signed({1'b0, center_x_twice});
                    y2_reg   <= $signed({1'b0, s_pixel_y, 1'b0}) - $signed({1'b0, center_y_twice});
                    last_reg <= s_last_pixel;
                end
            end
            rrha_pkg::F_SQUARE: begin
                sq_reg <= rrha_pkg::SQ_BITS'(rrha_pkg::abs_diff(it_reg) * rrha_pkg::abs_diff(it_reg));
            end
            rrha_pkg::F_PROD: begin
                den_reg <= (rrha_pkg::DEN_BITS'(1) << 32) + rrha_pkg::DEN_BITS'(p_val);
            end
            rrha_pkg::F_DINIT: begin
                rem_reg     <= rrha_pkg::DEN_BITS'(num_val >> WB);
                num_low_reg <= num_val[WB-1:0];
                quo_reg     <= '0;
                cnt_reg     <= rrha_pkg::WCNT_BITS'(WB - 1);
            end
            rrha_pkg::F_DIV: begin
                // Restoring division, one quotient bit per cycle.
                rem_reg     <= trial_ge ? rrha_pkg::DEN_BITS'(trial - {1'b0, den_reg})
                                        : rrha_pkg::DEN_BITS'(trial);
                quo_reg     <= {quo_reg[WB-2:0], trial_ge};
                num_low_reg <= {num_low_reg[WB-2:0], 1'b0};
                cnt_reg     <= cnt_reg - 1'b1;
            end
            rrha_pkg::F_SCALE: begin
                dx_reg <= scale_w(dx_reg, quo_reg);
                dy_reg <= scale_w(dy_reg, quo_reg);
                it_reg <= scale_w(it_reg, quo_reg);
            end
            rrha_pkg::F_MULT: begin
                p0_reg <= x2_reg * dx_reg;
                p1_reg <= y2_reg * dy_reg;
                p2_reg <= y2_reg * dx_reg;
                p3_reg <= x2_reg * dy_reg;
            end
            rrha_pkg::F_PUSH: begin
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- rtl/rrha_back.sv -----
// Back end: multiplies e terms into 14 saturating accumulators and streams the sums out.
module rrha_back (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  rrha_pkg::eterm_item_t                  pop_item,
    input  logic                                   empty,
    output logic                                   pop,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [rrha_pkg::IDX_BITS-1:0]          m_sum_index,
    output logic signed [rrha_pkg::ACC_BITS-1:0]   m_sum_value,
    output logic                                   m_sum_saturated,
    output logic                                   m_last_sum
);
    localparam int MB = rrha_pkg::MUL_BITS;
    localparam int AB = rrha_pkg::ACC_BITS;
    localparam int DB = rrha_pkg::DIFF_BITS;
    localparam logic signed [AB-1:0] ACC_MAX = {1'b0, {(AB-1){1'b1}}};
    localparam logic signed [AB-1:0] ACC_MIN = {1'b1, {(AB-1){1'b0}}};

    rrha_pkg::back_state_t state_reg, state_next;

    logic signed [MB-1:0] e_reg [4];
    logic signed [MB-1:0] nt_reg;
    logic                 last_reg;
    logic [rrha_pkg::IDX_BITS-1:0] k_reg;
    logic signed [2*MB-1:0] prod_reg;
    logic [rrha_pkg::IDX_BITS-1:0] prod_idx_reg;
    logic prod_vld_reg;

    logic signed [AB-1:0] acc_reg [rrha_pkg::NUM_SUMS];
    logic [rrha_pkg::NUM_SUMS-1:0] mark_reg;

    logic m_valid_reg, m_sat_reg, m_last_reg;
    logic [rrha_pkg::IDX_BITS-1:0] m_index_reg;
    logic signed [AB-1:0] m_value_reg;

    logic out_free, emit_go, mac_mul;
    logic signed [MB-1:0] op_a, op_b;
    logic [rrha_pkg::IDX_BITS-1:0] rd_idx;
    logic signed [AB-1:0] acc_rd;
    logic [AB:0] acc_sum;
    logic acc_ovf;

    assign out_free = !m_valid_reg || m_ready;
    assign rd_idx   = (state_reg == rrha_pkg::B_EMIT) ? k_reg : prod_idx_reg;
    assign acc_rd   = acc_reg[rd_idx];
    assign acc_sum  = {acc_rd[AB-1], acc_rd} + {prod_reg[AB-1], prod_reg[AB-1:0]};
    assign acc_ovf  = acc_sum[AB] ^ acc_sum[AB-1];

    always_comb begin
        if (k_reg < rrha_pkg::FIRST_B) begin
            op_a = e_reg[rrha_pkg::hess_row(k_reg)];
            op_b = e_reg[rrha_pkg::hess_col(k_reg)];
        end else begin
            op_a = e_reg[2'(k_reg - rrha_pkg::FIRST_B)];
            op_b = nt_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rrha_pkg::B_IDLE: begin
                if (!empty) begin
                    state_next = rrha_pkg::B_MAC;
                end
            end
            rrha_pkg::B_MAC: begin
                if (k_reg == rrha_pkg::MAC_END) begin
                    state_next = last_reg ? rrha_pkg::B_EMIT : rrha_pkg::B_IDLE;
                end
            end
            rrha_pkg::B_EMIT: begin
                if (out_free && (k_reg == rrha_pkg::LAST_INDEX)) begin
                    state_next = rrha_pkg::B_IDLE;
                end
            end
            default: state_next = rrha_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        pop     = (state_reg == rrha_pkg::B_IDLE) && !empty;
        mac_mul = (state_reg == rrha_pkg::B_MAC) && (k_reg != rrha_pkg::MAC_END);
        emit_go = (state_reg == rrha_pkg::B_EMIT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rrha_pkg::B_IDLE;
            k_reg        <= '0;
            prod_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            mark_reg     <= '0;
            for (int i = 0; i < rrha_pkg::NUM_SUMS; i++) begin
                acc_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            prod_vld_reg <= mac_mul;
            if (pop) begin
                k_reg <= '0;
            end else if (mac_mul || emit_go) begin
                k_reg <= k_reg + 1'b1;
            end else if (state_reg == rrha_pkg::B_MAC) begin
                k_reg <= '0;
            end
            if (prod_vld_reg) begin
                acc_reg[rd_idx] <= acc_ovf ? (acc_sum[AB] ? ACC_MIN : ACC_MAX)
                                           : acc_sum[AB-1:0];
                if (acc_ovf) begin
                    mark_reg[rd_idx] <= 1'b1;
                end
            end
            if (emit_go) begin
                acc_reg[rd_idx]  <= '0;
                mark_reg[rd_idx] <= 1'b0;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            e_reg[0] <= MB'(pop_item.e0);
            e_reg[1] <= MB'(pop_item.e1);
            e_reg[2] <= {{(MB-DB-1){pop_item.dx[DB-1]}}, pop_item.dx, 1'b0};
            e_reg[3] <= {{(MB-DB-1){pop_item.dy[DB-1]}}, pop_item.dy, 1'b0};
            nt_reg   <= -{{(MB-DB-2){pop_item.it[DB-1]}}, pop_item.it, 2'b00};
            last_reg <= pop_item.last;
        end
        if (mac_mul) begin
            prod_reg     <= op_a * op_b;
            prod_idx_reg <= k_reg;
        end
        if (emit_go) begin
            m_index_reg <= k_reg;
            m_value_reg <= acc_rd;
            m_sat_reg   <= mark_reg[rd_idx];
            m_last_reg  <= (k_reg == rrha_pkg::LAST_INDEX);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_sum_index     = m_index_reg;
    assign m_sum_value     = m_value_reg;
    assign m_sum_saturated = m_sat_reg;
    assign m_last_sum      = m_last_reg;

endmodule

// ----- rtl/robust_rotzoom_hessian_accumulator.sv -----
// Robust rotation-zoom-translation Hessian accumulator, top level.
//
// The input channel (s_) takes one pixel per item: four warped neighbours, the warped
// and reference centre samples, the pixel position, an invalid flag and a last flag.
// The result channel (m_) gives 14 items after each pixel marked last: ten Hessian
// sums, then four right-hand sums, each with its saturation mark; the final one
// carries last_sum. Registers are written through cfg_wr_en/cfg_index/cfg_wr_data.
// A front stage takes a pixel and, with weighting on, forms its robust weight with a
// serial divider; it accepts a new pixel only after it has pushed the previous one.
// A two-entry queue feeds the back stage, which runs the 14 products through one
// shared multiplier and takes the next pixel from the queue only once all 14 products
// of the current one are formed. After a last pixel the back stage emits the 14 sums
// one per cycle, clearing each accumulator as it goes out; a stalled receiver holds
// the emission and, through the queue, eventually the input. Reset clears the
// registers, the sums and the marks at once.
`include "robust_rotzoom_hessian_accumulator_macros.svh"

module robust_rotzoom_hessian_accumulator (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       cfg_wr_en,
    input  logic [rrha_pkg::CFG_IDX_BITS-1:0]          cfg_index,
    input  logic [rrha_pkg::CFG_DATA_BITS-1:0]         cfg_wr_data,
    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  logic signed [rrha_pkg::SAMPLE_BITS-1:0]    s_warped_right,
    input  logic signed [rrha_pkg::SAMPLE_BITS-1:0]    s_warped_left,
    input  logic signed [rrha_pkg::SAMPLE_BITS-1:0]    s_warped_up,
    input  logic signed [rrha_pkg::SAMPLE_BITS-1:0]    s_warped_down,
    input  logic signed [rrha_pkg::SAMPLE_BITS-1:0]    s_warped_center,
    input  logic signed [rrha_pkg::SAMPLE_BITS-1:0]    s_reference_center,
    input  logic [rrha_pkg::COORD_BITS-1:0]            s_pixel_x,
    input  logic [rrha_pkg::COORD_BITS-1:0]            s_pixel_y,
    input  logic                                       s_sample_invalid,
    input  logic                                       s_last_pixel,
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic [rrha_pkg::IDX_BITS-1:0]              m_sum_index,
    output logic signed [rrha_pkg::ACC_BITS-1:0]       m_sum_value,
    output logic                                       m_sum_saturated,
    output logic                                       m_last_sum
);
    logic [rrha_pkg::CX_BITS-1:0]  center_x_twice_reg, center_y_twice_reg;
    logic [rrha_pkg::THR_BITS-1:0] grad_threshold_reg;
    logic                          weight_enable_reg;
    logic [rrha_pkg::INV_BITS-1:0] inv_sigma_sq_reg;

    logic fifo_push, fifo_pop, fifo_full, fifo_empty;
    rrha_pkg::eterm_item_t push_item, pop_item;

    logic out_fire, out_at_first, out_at_last;

    assign out_fire     = m_valid && m_ready;
    assign out_at_first = (m_sum_index == '0);
    assign out_at_last  = (m_sum_index == rrha_pkg::LAST_INDEX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_twice_reg <= '0;
            center_y_twice_reg <= '0;
            grad_threshold_reg <= '0;
            weight_enable_reg  <= 1'b0;
            inv_sigma_sq_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rrha_pkg::CFG_CENTER_X:  center_x_twice_reg <= cfg_wr_data[rrha_pkg::CX_BITS-1:0];
                rrha_pkg::CFG_CENTER_Y:  center_y_twice_reg <= cfg_wr_data[rrha_pkg::CX_BITS-1:0];
                rrha_pkg::CFG_THRESHOLD: grad_threshold_reg <= cfg_wr_data[rrha_pkg::THR_BITS-1:0];
                rrha_pkg::CFG_WEIGHT_EN: weight_enable_reg  <= cfg_wr_data[0];
                rrha_pkg::CFG_INV_SIGMA: inv_sigma_sq_reg   <= cfg_wr_data[rrha_pkg::INV_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    rrha_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_warped_right     (s_warped_right),
        .s_warped_left      (s_warped_left),
        .s_warped_up        (s_warped_up),
        .s_warped_down      (s_warped_down),
        .s_warped_center    (s_warped_center),
        .s_reference_center (s_reference_center),
        .s_pixel_x          (s_pixel_x),
        .s_pixel_y          (s_pixel_y),
        .s_sample_invalid   (s_sample_invalid),
        .s_last_pixel       (s_last_pixel),
        .center_x_twice     (center_x_twice_reg),
        .center_y_twice     (center_y_twice_reg),
        .grad_threshold     (grad_threshold_reg),
        .weight_enable      (weight_enable_reg),
        .inv_sigma_sq       (inv_sigma_sq_reg),
        .push               (fifo_push),
        .push_item          (push_item),
        .full               (fifo_full)
    );

    rrha_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .pop_item  (pop_item),
        .empty     (fifo_empty)
    );

    rrha_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pop_item        (pop_item),
        .empty           (fifo_empty),
        .pop             (fifo_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sum_index     (m_sum_index),
        .m_sum_value     (m_sum_value),
        .m_sum_saturated (m_sum_saturated),
        .m_last_sum      (m_last_sum)
    );

    `RRHA_ASSERT_SAME(a_no_overflow, aclk, aresetn, fifo_push, !fifo_full)
    `RRHA_ASSERT_SAME(a_no_underflow, aclk, aresetn, fifo_pop, !fifo_empty)
    `RRHA_ASSERT_SAME(a_last_index, aclk, aresetn, m_valid && m_last_sum, out_at_last)
    `RRHA_ASSERT_NEXT(a_index_steps, aclk, aresetn, out_fire && !m_last_sum, !m_valid || !out_at_first)

endmodule
